@@ design/ip_range_to_prefix_blocks_core_macros.svh @@
// Assertion macros shared by the range-to-prefix RTL.
// Each macro expects signals named clk and rst in the scope where it is used.
`ifndef IP_RANGE_TO_PREFIX_BLOCKS_CORE_MACROS_SVH
`define IP_RANGE_TO_PREFIX_BLOCKS_CORE_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define IPR2P_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define IPR2P_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ design/ipr2p_pkg.sv @@
// Shared types and constants for the range-to-prefix block.
// No dependencies; the sequencer, output stage, top level and bench import this package.
package ipr2p_pkg;

  // Sequencer states.
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CALL,
    ST_SCAN,
    ST_ALIGN,
    ST_LEFT,
    ST_CONT,
    ST_STEP,
    ST_RET,
    ST_POP,
    ST_ERR,
    ST_FIN
  } seq_state_t;

  // Status codes carried by every result of one range.
  localparam logic [1:0] STATUS_OK     = 2'd0;
  localparam logic [1:0] STATUS_ORDER  = 2'd1;
  localparam logic [1:0] STATUS_SINGLE = 2'd2;

  // Results per range are capped; the last one kept is marked final.
  localparam int unsigned MAX_RESULTS = 62;

  // One result as produced by the sequencer, before the last mark is known.
  typedef struct packed {
    logic [31:0] base;
    logic [5:0]  plen;
    logic        valid;
    logic [1:0]  status;
  } blk_t;

  // Sequencer requests toward the output stage.
  typedef struct packed {
    logic emit;
    logic finish;
  } seq_ctl_t;

endpackage

@@ design/ipr2p_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module ipr2p_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ design/ipr2p_outq.sv @@
// Output stage: one-result hold register plus the output register.
// Depends on ipr2p_pkg and the assertion macro header.
`include "ip_range_to_prefix_blocks_core_macros.svh"

module ipr2p_outq (
  input  logic                 clk,
  input  logic                 rst,
  input  ipr2p_pkg::blk_t      blk,
  input  ipr2p_pkg::seq_ctl_t  ctl,
  output logic                 ready,
  output logic                 block_valid,
  input  logic                 block_stall,
  output logic [31:0]          block_base,
  output logic [5:0]           prefix_length,
  output logic                 entry_valid,
  output logic [1:0]           status,
  output logic                 last_block
);
  import ipr2p_pkg::*;

  blk_t hold;
  logic hold_full;
  logic out_free;
  logic load_out;

  // A result waits in the hold register until the sequencer either produces
  // the next one or finishes, which tells whether it is the final item.
  assign out_free = !block_valid || !block_stall;
  assign ready    = !hold_full || out_free;
  assign load_out = (ctl.emit || ctl.finish) && ready && hold_full;

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_full   <= 1'b0;
      block_valid <= 1'b0;
    end else begin
      if (ctl.emit && ready) begin
        hold_full <= 1'b1;
      end else if (ctl.finish && ready) begin
        hold_full <= 1'b0;
      end
      if (load_out) begin
        block_valid <= 1'b1;
      end else if (!block_stall) begin
        block_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.emit && ready) begin
      hold <= blk;
    end
    if (load_out) begin
      block_base    <= hold.base;
      prefix_length <= hold.plen;
      entry_valid   <= hold.valid;
      status        <= hold.status;
      last_block    <= ctl.finish;
    end
  end

  `IPR2P_ASSERT_IMP(a_finish_has_item, ctl.finish && ready, hold_full,
    "finish with no result waiting in the hold register")
  `IPR2P_ASSERT_NXT(a_finish_drains, ctl.finish && ready, !hold_full,
    "hold register still full after the final item left")

endmodule

@@ design/ipr2p_seq.sv @@
// Range decomposition sequencer: one shared adder, a bit-serial leading-one
// search and a return stack in RAM. Depends on ipr2p_pkg, ipr2p_ram and the
// assertion macro header.
`include "ip_range_to_prefix_blocks_core_macros.svh"

module ipr2p_seq #(
  parameter int unsigned ADDRESS_BITS = 32
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 range_valid,
  output logic                 range_stall,
  input  logic [31:0]          start_address,
  input  logic [31:0]          end_address,
  input  logic                 out_ready,
  output ipr2p_pkg::blk_t      blk,
  output ipr2p_pkg::seq_ctl_t  ctl
);
  import ipr2p_pkg::*;

  localparam int unsigned KW = $clog2(ADDRESS_BITS);
  localparam int unsigned EW = 2 * ADDRESS_BITS + KW;
  localparam logic [ADDRESS_BITS-1:0] ALL_ONES = '1;
  localparam logic [KW-1:0] K_TOP = KW'(ADDRESS_BITS - 1);
  localparam logic [KW-1:0] SP_TOP = KW'(ADDRESS_BITS - 1);
  localparam logic [5:0] PLEN_FULL = 6'(ADDRESS_BITS);
  localparam logic [5:0] CNT_LAST = 6'(MAX_RESULTS - 1);

  seq_state_t state, state_next;

  logic [ADDRESS_BITS-1:0] lo, hi, base, diff;
  logic [KW-1:0]           k, sp;
  logic [1:0]              status;
  logic [5:0]              count;

  logic [ADDRESS_BITS-1:0] s_in, e_in;
  logic [ADDRESS_BITS-1:0] lowm, end_blk, base_w;
  logic [KW-1:0]           k_dec, sp_dec;
  logic [ADDRESS_BITS-1:0] opa, opb;
  logic                    cin;
  logic [ADDRESS_BITS:0]   sum;
  logic [ADDRESS_BITS-1:0] sum_lo;
  logic                    sum_zero, carry;
  logic                    go, push;
  logic [EW-1:0]           stack_rd;

  function automatic blk_t single_blk(input logic [ADDRESS_BITS-1:0] a,
                                      input logic [1:0] st);
    blk_t r;
    r.base   = 32'(a);
    r.plen   = PLEN_FULL;
    r.valid  = (a != '0) && (a != ALL_ONES);
    r.status = st;
    return r;
  endfunction

  assign s_in    = start_address[ADDRESS_BITS-1:0];
  assign e_in    = end_address[ADDRESS_BITS-1:0];
  assign lowm    = ~(ALL_ONES << k);
  assign end_blk = base | lowm;
  assign k_dec   = (k == '0) ? '0 : k - KW'(1);
  assign sp_dec  = sp - KW'(1);

  // Shared adder. Subtractions use the inverted operand with carry in; the
  // carry out then means "a is not below b".
  always_comb begin
    opa = '0;
    opb = '0;
    cin = 1'b0;
    case (state)
      ST_IDLE: begin
        opa = e_in;
        opb = ~s_in;
        cin = 1'b1;
      end
      ST_CALL: begin
        opa = hi;
        opb = ~lo;
        cin = 1'b1;
      end
      ST_ALIGN: begin
        opa = lo;
        opb = lowm;
      end
      ST_LEFT: begin
        opa = base;
        opb = ALL_ONES;
      end
      ST_CONT: begin
        opa = hi;
        opb = ~end_blk;
        cin = 1'b1;
      end
      ST_STEP: begin
        opa = end_blk;
        cin = 1'b1;
      end
      default: ;
    endcase
  end

  assign sum      = {1'b0, opa} + {1'b0, opb} + (ADDRESS_BITS + 1)'(cin);
  assign sum_lo   = sum[ADDRESS_BITS-1:0];
  assign sum_zero = (sum_lo == '0);
  assign carry    = sum[ADDRESS_BITS];
  assign base_w   = sum_lo & ~lowm;

  // Outputs of the sequencer.
  always_comb begin
    ctl         = '0;
    blk         = '0;
    push        = 1'b0;
    range_stall = (state != ST_IDLE);
    unique case (state)
      ST_CALL: begin
        if (sum_zero) begin
          ctl.emit = 1'b1;
          blk      = single_blk(lo, status);
        end
      end
      ST_ALIGN: begin
        push = (base_w != lo);
      end
      ST_CONT: begin
        if (base == hi) begin
          ctl.emit = 1'b1;
          blk      = single_blk(base, status);
        end else if (carry) begin
          ctl.emit   = 1'b1;
          blk.base   = 32'(base);
          blk.plen   = PLEN_FULL - 6'(k);
          blk.valid  = !((base == ALL_ONES) && (k == '0));
          blk.status = status;
        end
      end
      ST_ERR: begin
        ctl.emit   = 1'b1;
        blk.status = status;
      end
      ST_FIN: begin
        ctl.finish = 1'b1;
      end
      default: ;
    endcase
  end

  assign go = out_ready || !(ctl.emit || ctl.finish);

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:  if (range_valid) state_next = carry ? ST_CALL : ST_ERR;
      ST_CALL:  state_next = sum_zero ? ST_RET : ST_SCAN;
      ST_SCAN:  if (diff[k]) state_next = ST_ALIGN;
      ST_ALIGN: state_next = (base_w != lo) ? ST_LEFT : ST_CONT;
      ST_LEFT:  state_next = ST_CALL;
      ST_CONT: begin
        if (base == hi) begin
          state_next = ST_RET;
        end else if (carry) begin
          // A block that ends exactly at hi closes this frame.
          state_next = sum_zero ? ST_RET : ST_STEP;
        end else begin
          state_next = ST_CALL;
        end
      end
      ST_STEP:  state_next = ST_CALL;
      ST_RET:   state_next = (sp == '0) ? ST_FIN : ST_POP;
      ST_POP:   state_next = ST_CONT;
      ST_ERR:   state_next = ST_FIN;
      ST_FIN:   state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
    if (ctl.emit && (count == CNT_LAST)) begin
      state_next = ST_FIN;
    end
    if (!go) begin
      state_next = state;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      sp    <= '0;
      count <= '0;
    end else begin
      state <= state_next;
      if (go) begin
        if (state == ST_IDLE && range_valid) begin
          sp    <= '0;
          count <= '0;
        end else if (ctl.emit) begin
          count <= count + 6'd1;
        end
        if (push) begin
          sp <= sp + KW'(1);
        end else if (state == ST_RET && sp != '0) begin
          sp <= sp_dec;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      unique case (state)
        ST_IDLE: begin
          if (range_valid) begin
            lo <= s_in;
            hi <= e_in;
            k  <= K_TOP;
            if (!carry) begin
              status <= STATUS_ORDER;
            end else if (sum_zero) begin
              status <= STATUS_SINGLE;
            end else begin
              status <= STATUS_OK;
            end
          end
        end
        ST_CALL:  diff <= sum_lo;
        ST_SCAN:  if (!diff[k]) k <= k - KW'(1);
        ST_ALIGN: base <= base_w;
        ST_LEFT: begin
          hi <= sum_lo;
          k  <= k_dec;
        end
        ST_CONT: begin
          if (base != hi && !carry) begin
            lo <= base;
            k  <= k_dec;
          end
        end
        ST_STEP: begin
          lo <= sum_lo;
          k  <= k_dec;
        end
        ST_POP: {base, hi, k} <= stack_rd;
        default: ;
      endcase
    end
  end

  // Pending frames waiting for their left part to finish.
  ipr2p_ram #(
    .WIDTH(EW),
    .DEPTH(ADDRESS_BITS)
  ) u_stack (
    .clk  (clk),
    .we   (push && go),
    .waddr(sp),
    .wdata({base_w, hi, k}),
    .raddr(sp_dec),
    .rdata(stack_rd)
  );

  `IPR2P_ASSERT_IMP(a_stack_bound, push, sp != SP_TOP,
    "return stack pushed past its last entry")
  `IPR2P_ASSERT_IMP(a_scan_hits, (state == ST_SCAN) && (k == '0), diff[0],
    "leading-one search ran past bit zero")
  `IPR2P_ASSERT_NXT(a_ret_pops, (state == ST_RET) && (sp != '0), state == ST_POP,
    "return with pending frames did not pop the stack")

endmodule

@@ design/ip_range_to_prefix_blocks_core.sv @@
// Top level of the address range to prefix block decomposer.
// Depends on ipr2p_pkg, ipr2p_seq, ipr2p_outq and ipr2p_ram.

// One item is an inclusive address range; the block answers with the prefix
// blocks that cover it, in ascending order, one result each, and marks the
// final result with last_block. Only the low ADDRESS_BITS bits of each address
// are used. Start above end yields one result with status 1 and no entry;
// start equal to end yields one single-address result with status 2. A range
// is taken only while the sequencer is idle, but a finished result may still
// be waiting at the output then. The sequencer uses one adder and a
// one-bit-per-cycle leading-one search; the searches in one range walk at
// most ADDRESS_BITS bits down each call chain. At most 62 results are given
// per range.
module ip_range_to_prefix_blocks_core #(
  parameter int unsigned ADDRESS_BITS = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        range_valid,
  output logic        range_stall,
  input  logic [31:0] start_address,
  input  logic [31:0] end_address,
  output logic        block_valid,
  input  logic        block_stall,
  output logic [31:0] block_base,
  output logic [5:0]  prefix_length,
  output logic        entry_valid,
  output logic [1:0]  status,
  output logic        last_block
);
  import ipr2p_pkg::*;

  blk_t     blk;
  seq_ctl_t ctl;
  logic     out_ready;

  ipr2p_seq #(
    .ADDRESS_BITS(ADDRESS_BITS)
  ) u_seq (
    .clk          (clk),
    .rst          (rst),
    .range_valid  (range_valid),
    .range_stall  (range_stall),
    .start_address(start_address),
    .end_address  (end_address),
    .out_ready    (out_ready),
    .blk          (blk),
    .ctl          (ctl)
  );

  ipr2p_outq u_outq (
    .clk          (clk),
    .rst          (rst),
    .blk          (blk),
    .ctl          (ctl),
    .ready        (out_ready),
    .block_valid  (block_valid),
    .block_stall  (block_stall),
    .block_base   (block_base),
    .prefix_length(prefix_length),
    .entry_valid  (entry_valid),
    .status       (status),
    .last_block   (last_block)
  );

endmodule

@@ bench/ip_range_to_prefix_blocks_core_tb.sv @@
// Self-checking bench for ip_range_to_prefix_blocks_core: drives address ranges
// and checks every emitted prefix block against an in-bench decomposition.
// Depends on ipr2p_pkg and the core RTL only.
`timescale 1ns / 100ps

module ip_range_to_prefix_blocks_core_tb;
  import ipr2p_pkg::*;

  localparam int unsigned ADDR_W      = 32;
  localparam logic [31:0] ADDR_MASK   = 32'hFFFF_FFFF >> (32 - ADDR_W);
  localparam int          RANDOM_RANGES = 500;
  localparam int          CYCLE_LIMIT = 4_000_000;
  localparam int          DRAIN_CYCLES = 500;
  localparam int          HOLD_CYCLES = 800;

  typedef struct packed {
    logic [31:0] base;
    logic [5:0]  plen;
    logic        entry;
    logic [1:0]  st;
    logic        last;
  } prefix_blk_t;

  // One pending piece of a decomposition. A rest frame continues a range
  // whose unaligned low part has already been covered.
  typedef struct {
    logic        rest;
    logic [31:0] lo;
    logic [31:0] hi;
    int          k;
  } cover_frame_t;

  class prefix_scoreboard;
    prefix_blk_t expected_blocks[$];
    prefix_blk_t range_blocks[$];
    int          failures;
    int          blocks_seen;

    function void add_block(logic [31:0] base, logic [5:0] plen, logic entry,
                            logic [1:0] st);
      prefix_blk_t blk;
      if (range_blocks.size() >= MAX_RESULTS) return;
      blk.base  = base;
      blk.plen  = plen;
      blk.entry = entry;
      blk.st    = st;
      blk.last  = 1'b0;
      range_blocks.insert(range_blocks.size(), blk);
    endfunction

    // Lone addresses at either end of the space carry no entry.
    function void add_host(logic [31:0] addr, logic [1:0] st);
      add_block(addr, 6'(ADDR_W), (addr != 32'd0) && (addr != ADDR_MASK), st);
    endfunction

    function void note_range(logic [31:0] first_addr, logic [31:0] last_addr);
      cover_frame_t work[$];
      cover_frame_t fr;
      logic [31:0]  lo, hi, base, span, mask, size;
      int           k;
      lo = first_addr & ADDR_MASK;
      hi = last_addr & ADDR_MASK;
      range_blocks.delete();
      if (lo > hi) add_block(32'd0, 6'd0, 1'b0, STATUS_ORDER);
      else if (lo == hi) add_host(lo, STATUS_SINGLE);
      else work.insert(work.size(), cover_frame_t'{1'b0, lo, hi, 0});

      while (work.size() > 0) begin
        fr = work.pop_back();
        lo = fr.lo;
        hi = fr.hi;
        k  = fr.k;
        if (!fr.rest) begin
          if (lo == hi) begin
            add_host(lo, STATUS_OK);
            continue;
          end
          span = hi - lo;
          k = 31;
          while (k > 0 && !span[k]) k--;
          size = 32'd1 << k;
          mask = ADDR_MASK & ~(size - 32'd1);
          base = lo & mask;
          if (base < lo) base += size;
          if (base > lo) begin
            // Cover the part below the boundary first, then come back here.
            work.insert(work.size(), cover_frame_t'{1'b1, base, hi, k});
            work.insert(work.size(), cover_frame_t'{1'b0, lo, base - 32'd1, 0});
            continue;
          end
        end
        size = 32'd1 << k;
        mask = ADDR_MASK & ~(size - 32'd1);
        base = lo;
        if (lo == hi) begin
          add_host(lo, STATUS_OK);
          continue;
        end
        if (base + (size - 32'd1) <= hi) begin
          add_block(base, 6'(ADDR_W - k), !(base == ADDR_MASK && mask == ADDR_MASK),
                    STATUS_OK);
          if (base + (size - 32'd1) == ADDR_MASK) continue;
          lo = base + size;
        end
        if (lo == hi) add_host(lo, STATUS_OK);
        else if (lo < hi) work.insert(work.size(), cover_frame_t'{1'b0, lo, hi, 0});
      end

      if (range_blocks.size() > 0) range_blocks[range_blocks.size() - 1].last = 1'b1;
      foreach (range_blocks[i]) expected_blocks.insert(expected_blocks.size(), range_blocks[i]);
    endfunction

    function void check_block(logic [31:0] base, logic [5:0] plen, logic entry,
                              logic [1:0] st, logic last);
      prefix_blk_t want;
      blocks_seen++;
      if (expected_blocks.size() == 0) begin
        failures++;
        if (failures <= 10)
          $display("unexpected block: base=%h plen=%0d entry=%b status=%0d last=%b",
                   base, plen, entry, st, last);
        return;
      end
      want = expected_blocks.pop_front();
      if (want.base !== base || want.plen !== plen || want.entry !== entry ||
          want.st !== st || want.last !== last) begin
        failures++;
        if (failures <= 10)
          $display("block mismatch: expected base=%h plen=%0d entry=%b status=%0d last=%b",
                   want.base, want.plen, want.entry, want.st, want.last,
                   ", got base=%h plen=%0d entry=%b status=%0d last=%b",
                   base, plen, entry, st, last);
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst;
  logic        range_valid;
  logic        range_stall;
  logic [31:0] start_address;
  logic [31:0] end_address;
  logic        block_valid;
  logic        block_stall;
  logic [31:0] block_base;
  logic [5:0]  prefix_length;
  logic        entry_valid;
  logic [1:0]  status;
  logic        last_block;

  prefix_scoreboard sb = new();
  int send_idle_pct = 30;
  int recv_idle_pct = 83;
  bit hold_request  = 1'b0;
  bit hold_done     = 1'b0;
  int hold_left     = 0;
  int cycle_count   = 0;

  ip_range_to_prefix_blocks_core #(.ADDRESS_BITS(ADDR_W)) dut (
    .clk           (clk),
    .rst           (rst),
    .range_valid   (range_valid),
    .range_stall   (range_stall),
    .start_address (start_address),
    .end_address   (end_address),
    .block_valid   (block_valid),
    .block_stall   (block_stall),
    .block_base    (block_base),
    .prefix_length (prefix_length),
    .entry_valid   (entry_valid),
    .status        (status),
    .last_block    (last_block)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Called at a falling edge; returns at the falling edge after acceptance
  // with range_valid still high, so back-to-back items need no extra edge.
  task automatic send_range(input logic [31:0] first_addr, input logic [31:0] last_addr);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      range_valid <= 1'b0;
      @(negedge clk);
    end
    start_address <= first_addr;
    end_address   <= last_addr;
    range_valid   <= 1'b1;
    do @(posedge clk); while (range_stall);
    sb.note_range(first_addr, last_addr);
    @(negedge clk);
  endtask

  // Receiver stall; a requested hold-off keeps it high for a long stretch.
  always @(negedge clk) begin
    if (rst) begin
      block_stall <= 1'b0;
    end else begin
      if (hold_request && !hold_done) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        block_stall <= 1'b1;
      end else begin
        block_stall <= ($urandom_range(0, 99) < recv_idle_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && block_valid && !block_stall)
      sb.check_block(block_base, prefix_length, entry_valid, status, last_block);
  end

  initial begin
    logic [31:0] a, b;
    int          pick, k;
    rst           = 1'b1;
    range_valid   = 1'b0;
    start_address = 32'd0;
    end_address   = 32'd0;
    repeat (5) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    send_range(32'h0000_0000, 32'h0000_0000);
    send_range(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_range(32'h0A00_0001, 32'h0A00_0001);
    send_range(32'h0000_0005, 32'h0000_0003);
    send_range(32'hFFFF_FFFF, 32'h0000_0000);
    send_range(32'h0000_0000, 32'hFFFF_FFFF);
    send_range(32'h0000_0001, 32'hFFFF_FFFE);
    send_range(32'h0000_0000, 32'h0000_0001);
    send_range(32'hFFFF_FFFE, 32'hFFFF_FFFF);
    send_range(32'hFFFF_FF00, 32'hFFFF_FFFF);
    send_range(32'h8000_0000, 32'hFFFF_FFFF);
    send_range(32'h0000_0000, 32'hFFFF_FFFE);
    send_range(32'h0000_0001, 32'hFFFF_FFFF);
    send_range(32'hC0A8_0000, 32'hC0A8_00FF);
    send_range(32'hC0A8_0001, 32'hC0A8_0100);
    send_range(32'h7FFF_FFFF, 32'h8000_0000);
    send_range(32'h5555_5555, 32'hAAAA_AAAA);

    for (int i = 0; i < RANDOM_RANGES; i++) begin
      if (i == RANDOM_RANGES / 3) begin
        send_idle_pct = 83;
        recv_idle_pct = 30;
      end else if (i == 2 * RANDOM_RANGES / 3) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      if (i == RANDOM_RANGES - 60) hold_request = 1'b1;
      pick = $urandom_range(0, 99);
      if (pick < 25) begin
        a = $urandom;
        b = $urandom;
      end else if (pick < 55) begin
        a = $urandom;
        b = a + $urandom_range(0, 600);
      end else if (pick < 65) begin
        k = $urandom_range(0, 31);
        a = $urandom & ~((32'd1 << k) - 32'd1);
        b = a + ((32'd1 << k) - 32'd1);
      end else if (pick < 75) begin
        case ($urandom_range(0, 3))
          0:       a = 32'h0000_0000;
          1:       a = 32'hFFFF_FFFF;
          default: a = $urandom;
        endcase
        b = a;
      end else if (pick < 85) begin
        a = 32'hFFFF_FFFF - $urandom_range(0, 5000);
        b = 32'hFFFF_FFFF - $urandom_range(0, 3);
      end else if (pick < 92) begin
        a = $urandom_range(0, 3);
        b = $urandom;
      end else begin
        b = $urandom;
        a = b + $urandom_range(1, 1000);
      end
      send_range(a, b);
    end
    range_valid <= 1'b0;

    while (sb.expected_blocks.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.failures == 0 && sb.expected_blocks.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
